>>> rtl/energy_containment_window_defines.svh
// Assertion macros shared by the energy containment window RTL.
`ifndef ENERGY_CONTAINMENT_WINDOW_DEFINES_SVH
`define ENERGY_CONTAINMENT_WINDOW_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ECW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecw assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ECW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecw assertion failed");

`endif

>>> rtl/ecw_pkg.sv
// Package: sizes, microcode word, status bundle and control program of the window block.
package ecw_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
  localparam int COUNT_BITS  = ADDR_BITS + 1;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
  localparam int E_BITS      = SQ_BITS + ADDR_BITS;
  localparam int W_BITS      = E_BITS + ADDR_BITS;
  localparam int KCNT_BITS   = $clog2(ADDR_BITS + 1);
  localparam int IDX_BITS    = 12;

  localparam int FRAC_BITS   = 17;
  localparam int FRAC_SHIFT  = 16;
  localparam logic [FRAC_BITS-1:0] FRAC_ONE   = 17'd65536;
  localparam logic [FRAC_BITS-1:0] FRAC_RESET = 17'd64881;
  localparam int LIMIT_BITS  = E_BITS + FRAC_SHIFT;
  localparam int E_LO_BITS   = (E_BITS + 1) / 2;
  localparam int E_HI_BITS   = E_BITS - E_LO_BITS;

  // program counter codes
  localparam int PC_BITS = 3;
  localparam logic [PC_BITS-1:0] P_LOAD  = 3'd0;
  localparam logic [PC_BITS-1:0] P_DRAIN = 3'd1;
  localparam logic [PC_BITS-1:0] P_INIT  = 3'd2;
  localparam logic [PC_BITS-1:0] P_DIV   = 3'd3;
  localparam logic [PC_BITS-1:0] P_LIMIT = 3'd4;
  localparam logic [PC_BITS-1:0] P_SQ    = 3'd5;
  localparam logic [PC_BITS-1:0] P_ACC   = 3'd6;
  localparam logic [PC_BITS-1:0] P_EMIT  = 3'd7;

  // jump condition codes
  localparam int COND_BITS = 3;
  localparam logic [COND_BITS-1:0] C_ALWAYS    = 3'd0;
  localparam logic [COND_BITS-1:0] C_LAST      = 3'd1;
  localparam logic [COND_BITS-1:0] C_ZERO      = 3'd2;
  localparam logic [COND_BITS-1:0] C_DIV_MORE  = 3'd3;
  localparam logic [COND_BITS-1:0] C_WALK_DONE = 3'd4;
  localparam logic [COND_BITS-1:0] C_OUT_FREE  = 3'd5;

  typedef struct packed {
    logic                 load_en;
    logic                 div_init;
    logic                 div_step;
    logic                 lim_init;
    logic                 sq_en;
    logic                 acc_en;
    logic                 emit;
    logic [COND_BITS-1:0] cond;
    logic [PC_BITS-1:0]   tgt_t;
    logic [PC_BITS-1:0]   tgt_f;
  } uword_t;

  typedef struct packed {
    logic last_acc;
    logic zero;
    logic div_more;
    logic walk_done;
    logic out_free;
  } status_t;

  function automatic logic [SQ_BITS-1:0] square_of(input logic signed [SAMPLE_BITS-1:0] s);
    logic signed [2*SAMPLE_BITS-1:0] p;
    p = s * s;
    return p[SQ_BITS-1:0];
  endfunction

  // control store: on a true condition go to tgt_t, else to tgt_f
  function automatic uword_t ucode(input logic [PC_BITS-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      P_LOAD: begin
        w.load_en = 1'b1;
        w.cond = C_LAST;     w.tgt_t = P_DRAIN; w.tgt_f = P_LOAD;
      end
      P_DRAIN: begin
        w.cond = C_ALWAYS;   w.tgt_t = P_INIT;  w.tgt_f = P_INIT;
      end
      P_INIT: begin
        w.div_init = 1'b1;
        w.cond = C_ZERO;     w.tgt_t = P_EMIT;  w.tgt_f = P_DIV;
      end
      P_DIV: begin
        w.div_step = 1'b1;
        w.cond = C_DIV_MORE; w.tgt_t = P_DIV;   w.tgt_f = P_LIMIT;
      end
      P_LIMIT: begin
        w.lim_init = 1'b1;
        w.cond = C_ALWAYS;   w.tgt_t = P_SQ;    w.tgt_f = P_SQ;
      end
      P_SQ: begin
        w.sq_en = 1'b1;
        w.cond = C_ALWAYS;   w.tgt_t = P_ACC;   w.tgt_f = P_ACC;
      end
      P_ACC: begin
        w.acc_en = 1'b1;
        w.cond = C_WALK_DONE; w.tgt_t = P_EMIT; w.tgt_f = P_SQ;
      end
      P_EMIT: begin
        w.emit = 1'b1;
        w.cond = C_OUT_FREE; w.tgt_t = P_LOAD;  w.tgt_f = P_EMIT;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/energy_containment_window.sv
// Top level of the energy containment window block: sequencer plus datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | input     | in_valid/in_stall  | in_sample (s16), in_last
//  out     | output    | out_valid/out_stall| out_begin_index, out_end_index, out_zero_energy
//  cfg     | input     | cfg_we             | cfg_data (containment fraction, Q16)
//
// Samples load one per cycle while the sequencer sits in its load step; a block
// then goes through drain, divide, limit and the outward walk steps (each step a
// square, then accumulate/compare while the two-port store is read).
// The center divider yields ADDR_BITS quotient bits, one per cycle.
// Reset (rst_n low, synchronous) clears the sums, counters and program counter;
// the fraction returns to 0.99 in Q16. The result sits in an output register, so a
// stalled result does not hold off loading of the next block.

module energy_containment_window (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [ecw_pkg::FRAC_BITS-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ecw_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ecw_pkg::IDX_BITS-1:0]           out_begin_index,
  output logic [ecw_pkg::IDX_BITS-1:0]           out_end_index,
  output logic                                   out_zero_energy
);

  ecw_pkg::uword_t  uw;
  ecw_pkg::status_t st;

  ecw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uw    (uw)
  );

  ecw_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_begin_index (out_begin_index),
    .out_end_index   (out_end_index),
    .out_zero_energy (out_zero_energy),
    .uw              (uw),
    .st              (st)
  );

endmodule

>>> rtl/ecw_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`include "energy_containment_window_defines.svh"

module ecw_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  ecw_pkg::status_t st,
  output ecw_pkg::uword_t  uw
);

  logic [ecw_pkg::PC_BITS-1:0] pc_r;
  logic [ecw_pkg::PC_BITS-1:0] pc_nxt;
  logic                        cond_true;

  assign uw = ecw_pkg::ucode(pc_r);

  always_comb begin
    unique case (uw.cond)
      ecw_pkg::C_ALWAYS:    cond_true = 1'b1;
      ecw_pkg::C_LAST:      cond_true = st.last_acc;
      ecw_pkg::C_ZERO:      cond_true = st.zero;
      ecw_pkg::C_DIV_MORE:  cond_true = st.div_more;
      ecw_pkg::C_WALK_DONE: cond_true = st.walk_done;
      ecw_pkg::C_OUT_FREE:  cond_true = st.out_free;
      default:              cond_true = 1'b0;
    endcase
  end

  assign pc_nxt = cond_true ? uw.tgt_t : uw.tgt_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ecw_pkg::P_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `ECW_ASSERT_NEXT(a_last_drains, st.last_acc && uw.load_en, pc_r == ecw_pkg::P_DRAIN)

endmodule

>>> rtl/ecw_datapath.sv
// Datapath: sample store, energy sums, center divider, limit product, outward walk, result register.
`include "energy_containment_window_defines.svh"

module ecw_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ecw_pkg::FRAC_BITS-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ecw_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ecw_pkg::IDX_BITS-1:0]          out_begin_index,
  output logic [ecw_pkg::IDX_BITS-1:0]          out_end_index,
  output logic                                  out_zero_energy,
  input  ecw_pkg::uword_t                       uw,
  output ecw_pkg::status_t                      st
);

  localparam int AB = ecw_pkg::ADDR_BITS;
  localparam int CB = ecw_pkg::COUNT_BITS;
  localparam int EB = ecw_pkg::E_BITS;
  localparam int WB = ecw_pkg::W_BITS;
  localparam int FB = ecw_pkg::FRAC_BITS;
  localparam int SB = ecw_pkg::SAMPLE_BITS;
  localparam int QB = ecw_pkg::SQ_BITS;
  localparam int LB = ecw_pkg::LIMIT_BITS;
  localparam int ELO = ecw_pkg::E_LO_BITS;
  localparam int EHI = ecw_pkg::E_HI_BITS;

  // config
  logic [FB-1:0] frac_r;
  logic [FB-1:0] frac_sat;

  // sample store
  logic signed [SB-1:0] mem [ecw_pkg::MAX_SAMPLES];
  logic signed [SB-1:0] rda_r, rdb_r;
  logic [AB-1:0]        rd_addr_a, rd_addr_b;

  // load
  logic          accept, store_ok;
  logic [CB-1:0] count_r;
  logic          ld_valid_r;
  logic [QB-1:0] ld_sq_r;
  logic [AB-1:0] ld_idx_r;
  logic [AB+QB-1:0] wprod;
  logic [EB-1:0] e_r;
  logic [WB-1:0] w_r;

  // center divider and limit
  logic [WB-1:0] rem_r, d_r;
  logic [AB-1:0] q_r;
  logic [ecw_pkg::KCNT_BITS-1:0] k_r;
  logic          div_ge;
  logic [FB+ELO-1:0] lim_lo_r;
  logic [FB+EHI-1:0] lim_hi_r;
  logic [FB+EB-1:0]  lim_full;
  logic [LB-1:0]     limit_r;

  // walk
  logic [CB-1:0] n_last, off, lo_full, hi_full, j_nxt;
  logic [AB-1:0] j_r, begin_r, end_r, cur_lo, cur_hi;
  logic          va_r, vb_r, nza_r, nzb_r, zero_r;
  logic [QB-1:0] sqa_r, sqb_r;
  logic [EB-1:0] sum_r, sum_nxt;
  logic          hit, j_nz;

  // result register
  logic          out_valid_r, out_zero_r, out_free, emit_fire;
  logic [AB-1:0] out_begin_r, out_end_r;

  assign frac_sat = (frac_r > ecw_pkg::FRAC_ONE) ? ecw_pkg::FRAC_ONE : frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= ecw_pkg::FRAC_RESET;
    end else if (cfg_we) begin
      frac_r <= cfg_data;
    end
  end

  // ---------------- load ----------------
  assign in_stall = !uw.load_en;
  assign accept   = in_valid && uw.load_en;
  assign store_ok = count_r < CB'(ecw_pkg::MAX_SAMPLES);
  assign wprod    = ld_idx_r * ld_sq_r;

  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      mem[count_r[AB-1:0]] <= in_sample;
    end
    rda_r <= mem[rd_addr_a];
    rdb_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    ld_sq_r  <= ecw_pkg::square_of(in_sample);
    ld_idx_r <= count_r[AB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ld_valid_r <= 1'b0;
      e_r        <= '0;
      w_r        <= '0;
    end else begin
      ld_valid_r <= accept && store_ok;
      if (emit_fire) begin
        count_r <= '0;
        e_r     <= '0;
        w_r     <= '0;
      end else begin
        if (accept && store_ok) begin
          count_r <= count_r + CB'(1);
        end
        if (ld_valid_r) begin
          e_r <= e_r + EB'(ld_sq_r);
          w_r <= w_r + WB'(wprod);
        end
      end
    end
  end

  // ---------------- center = W / E, one quotient bit per cycle ----------------
  assign div_ge   = rem_r >= d_r;
  assign lim_full = {lim_hi_r, {ELO{1'b0}}} + (FB+EB)'(lim_lo_r);

  always_ff @(posedge clk) begin
    if (uw.div_init) begin
      rem_r    <= w_r;
      d_r      <= WB'(e_r) << (AB - 1);
      q_r      <= '0;
      k_r      <= ecw_pkg::KCNT_BITS'(AB - 1);
      lim_lo_r <= frac_sat * e_r[ELO-1:0];
      lim_hi_r <= frac_sat * e_r[EB-1:ELO];
    end else if (uw.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - d_r;
      end
      q_r <= (q_r << 1) | AB'(div_ge);
      d_r <= d_r >> 1;
      k_r <= k_r - ecw_pkg::KCNT_BITS'(1);
    end
    if (uw.lim_init) begin
      limit_r <= lim_full[LB-1:0];
    end
  end

  // ---------------- outward walk ----------------
  assign n_last  = count_r - CB'(1);
  assign j_nxt   = CB'(j_r) + CB'(1);
  assign off     = uw.lim_init ? '0 : j_nxt;
  assign lo_full = CB'(q_r) - off;
  assign hi_full = CB'(q_r) + off;
  assign rd_addr_a = lo_full[AB-1:0];
  assign rd_addr_b = hi_full[AB-1:0];
  assign cur_lo  = q_r - j_r;
  assign cur_hi  = q_r + j_r;
  assign j_nz    = j_r != '0;
  assign sum_nxt = sum_r + EB'(sqa_r) + EB'(sqb_r);
  assign hit     = {sum_nxt, {ecw_pkg::FRAC_SHIFT{1'b0}}} > limit_r;

  always_ff @(posedge clk) begin
    if (uw.lim_init || uw.acc_en) begin
      va_r <= off <= CB'(q_r);
      vb_r <= !uw.lim_init && (hi_full <= n_last);
    end
    if (uw.sq_en) begin
      sqa_r <= va_r ? ecw_pkg::square_of(rda_r) : '0;
      sqb_r <= vb_r ? ecw_pkg::square_of(rdb_r) : '0;
      nza_r <= va_r && (rda_r != '0);
      nzb_r <= vb_r && (rdb_r != '0);
    end
    if (uw.div_init) begin
      zero_r  <= e_r == '0;
      begin_r <= '0;
      end_r   <= '0;
    end else if (uw.lim_init) begin
      sum_r   <= '0;
      j_r     <= '0;
      begin_r <= '0;
      end_r   <= n_last[AB-1:0];
    end else if (uw.acc_en) begin
      sum_r <= sum_nxt;
      j_r   <= j_nxt[AB-1:0];
      if (j_nz && nza_r) begin
        begin_r <= cur_lo;
      end
      if (j_nz && nzb_r) begin
        end_r <= cur_hi;
      end
    end
  end

  // ---------------- result register ----------------
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = uw.emit && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_begin_r <= begin_r;
      out_end_r   <= end_r;
      out_zero_r  <= zero_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_begin_index = ecw_pkg::IDX_BITS'(out_begin_r);
  assign out_end_index   = ecw_pkg::IDX_BITS'(out_end_r);
  assign out_zero_energy = out_zero_r;

  assign st.last_acc  = accept && in_last;
  assign st.zero      = e_r == '0;
  assign st.div_more  = k_r != '0;
  assign st.walk_done = (j_nz && hit) || (CB'(j_r) == n_last);
  assign st.out_free  = out_free;

  `ECW_ASSERT_IMP(a_sum_bounded, uw.acc_en, sum_nxt <= e_r)
  `ECW_ASSERT_IMP(a_center_in_block, uw.lim_init, CB'(q_r) <= n_last)
  `ECW_ASSERT_NEXT(a_emit_clears, emit_fire, out_valid_r && count_r == '0 && e_r == '0)

endmodule

>>> test/energy_containment_window_tb.sv
// Self-checking testbench for energy_containment_window: streams sample blocks, predicts windows.
module energy_containment_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SBITS = ecw_pkg::SAMPLE_BITS;
  localparam int FBITS = ecw_pkg::FRAC_BITS;
  localparam int IBITS = ecw_pkg::IDX_BITS;
  localparam int BLOCK_DEPTH = ecw_pkg::MAX_SAMPLES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 3000;
  localparam int IDLE_SETTLE = 8;
  localparam int END_SETTLE = 60;
  localparam int RANDOM_ITEMS = 650;

  typedef struct packed {
    logic [IBITS-1:0] begin_index;
    logic [IBITS-1:0] end_index;
    logic             zero_energy;
  } window_t;

  typedef enum {STYLE_FULL, STYLE_SMALL, STYLE_EXTREME, STYLE_SPARSE} sample_style_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [FBITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SBITS-1:0] in_sample = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IBITS-1:0] out_begin_index;
  logic [IBITS-1:0] out_end_index;
  logic out_zero_energy;

  // predictor state: open block and the fraction register
  int blk_sample[$];
  longint unsigned blk_energy = 0;
  longint unsigned blk_weighted = 0;
  logic [FBITS-1:0] fraction_reg = ecw_pkg::FRAC_RESET;
  window_t pending_windows[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  // sender pacing and receiver pattern
  int burst_left = 0;
  int gap_max = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int stall_span = 0;
  stall_mode_t stall_mode = STALL_NONE;

  energy_containment_window dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_begin_index(out_begin_index),
    .out_end_index(out_end_index),
    .out_zero_energy(out_zero_energy)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint unsigned energy_of(int s);
    return longint'(s) * longint'(s);
  endfunction

  // widen from the energy centroid until the running sum passes the fraction
  function automatic window_t containment_window();
    int n, m, j, lo, hi, a, b, win_lo, win_hi;
    longint unsigned e, lim, acc;
    logic [FBITS-1:0] fr;
    window_t w;
    n = blk_sample.size();
    e = blk_energy;
    w = '0;
    if (e == 0) begin
      w.zero_energy = 1'b1;
      return w;
    end
    fr = (fraction_reg > ecw_pkg::FRAC_ONE) ? ecw_pkg::FRAC_ONE : fraction_reg;
    lim = longint'(fr) * e;
    m = int'(blk_weighted / e);
    acc = energy_of(blk_sample[m]);
    win_lo = 0;
    win_hi = n - 1;
    for (j = 1; j < n; j++) begin
      lo = m - j;
      hi = m + j;
      a = (lo >= 0) ? blk_sample[lo] : 0;
      b = (hi < n) ? blk_sample[hi] : 0;
      if (a != 0) win_lo = lo;
      if (b != 0) win_hi = hi;
      acc += energy_of(a) + energy_of(b);
      if ((acc << 16) > lim) break;
    end
    w.begin_index = win_lo[IBITS-1:0];
    w.end_index = win_hi[IBITS-1:0];
    return w;
  endfunction

  function automatic void take_sample(int s, logic is_last);
    longint unsigned sq;
    // samples past a full block are dropped, but their last mark still counts
    if (blk_sample.size() < BLOCK_DEPTH) begin
      sq = energy_of(s);
      blk_weighted += longint'(blk_sample.size()) * sq;
      blk_energy += sq;
      blk_sample.push_back(s);
    end
    if (is_last) begin
      pending_windows.push_back(containment_window());
      blk_sample.delete();
      blk_energy = 0;
      blk_weighted = 0;
    end
  endfunction

  task automatic note_mismatch(string what, window_t want, window_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected begin=%0d end=%0d zero=%0d, got begin=%0d end=%0d zero=%0d",
               what, want.begin_index, want.end_index, want.zero_energy,
               got.begin_index, got.end_index, got.zero_energy);
  endtask

  always @(posedge clk) begin : watch_channels
    window_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_begin_index, out_end_index, out_zero_energy};
      if (pending_windows.size() == 0) begin
        note_mismatch("unexpected window", '0, got);
      end else begin
        want = pending_windows.pop_front();
        if (got.begin_index != want.begin_index || got.end_index != want.end_index ||
            got.zero_energy != want.zero_energy)
          note_mismatch("window mismatch", want, got);
      end
    end
    if (rst_n && in_valid && !in_stall)
      take_sample(int'(in_sample), in_last);
  end

  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(50, 400);
    end else begin
      stall_span--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycle_count[2];
      endcase
    end
  end

  // valid stays high on return so back-to-back items need no second assignment
  task automatic send_sample(input logic signed [SBITS-1:0] s, input logic is_last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    burst_left--;
    in_sample <= s;
    in_last <= is_last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait on the clock first so the monitor has booked the item accepted at the last edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_fraction(input logic [FBITS-1:0] v);
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    fraction_reg = v;
  endtask

  function automatic logic signed [SBITS-1:0] pick_sample(sample_style_t st);
    case (st)
      STYLE_SMALL: return SBITS'($signed($urandom_range(0, 6)) - 3);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(SBITS-1){1'b0}}};
          1: return {1'b0, {(SBITS-1){1'b1}}};
          2: return '1;
          3: return SBITS'(1);
          default: return '0;
        endcase
      end
      STYLE_SPARSE: return ($urandom_range(0, 3) == 0) ? SBITS'($urandom) : '0;
      default: return SBITS'($urandom);
    endcase
  endfunction

  task automatic send_block(input int n, input sample_style_t st);
    for (int i = 0; i < n; i++) send_sample(pick_sample(st), i == n - 1);
  endtask

  task automatic send_list(input int vals[$]);
    for (int i = 0; i < vals.size(); i++) send_sample(SBITS'(vals[i]), i == vals.size() - 1);
  endtask

  task automatic test_directed();
    gap_max = 3;
    send_list('{5});
    send_list('{0});
    send_list('{0, 0, 0});
    send_list('{-32768, 32767, 0, -1, 1});
    // all energy at the centroid: window edges stay at the block ends
    send_list('{0, 0, -32768, 0, 0});
    // centroid near the end, walk reaches the last sample of the block
    send_list('{1, 0, 0, 0, 0, 0, 0, 32767});
    wait_drained();
  endtask

  task automatic test_fraction_sweep();
    logic [FBITS-1:0] fracs[$];
    fracs = '{FBITS'(0), FBITS'(1), FBITS'(32768), FBITS'(65535), FBITS'(65536),
              FBITS'(65537), '1, FBITS'($urandom_range(0, 65536)), FBITS'($urandom),
              ecw_pkg::FRAC_RESET};
    gap_max = 2;
    foreach (fracs[k]) begin
      write_fraction(fracs[k]);
      repeat (3) send_block($urandom_range(1, 12), sample_style_t'($urandom_range(0, 3)));
      wait_drained();
    end
  endtask

  task automatic test_output_holdoff();
    gap_max = 0;
    hold_go = 1'b1;
    repeat (12) send_block($urandom_range(3, 6), STYLE_FULL);
    wait_drained();
    // sender idles until every window is back, then one more block
    send_block(4, STYLE_FULL);
    wait_drained();
  endtask

  task automatic test_block_overflow();
    gap_max = 0;
    send_block(BLOCK_DEPTH + 4, STYLE_SPARSE);
    wait_drained();
  endtask

  task automatic test_random_blocks();
    int sent, phase_end, n, r;
    sent = 0;
    phase_end = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= phase_end) begin
        wait_drained();
        r = $urandom_range(0, 3);
        write_fraction(r == 0 ? FBITS'($urandom) : FBITS'($urandom_range(58000, 65536)));
        r = $urandom_range(0, 2);
        gap_max = (r == 0) ? 0 : (r == 1) ? 2 : 10;
        phase_end = sent + $urandom_range(80, 140);
      end
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 12);
      else if (r < 95) n = $urandom_range(13, 64);
      else n = $urandom_range(65, 300);
      send_block(n, sample_style_t'($urandom_range(0, 3)));
      sent += n;
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fraction_sweep();
    test_output_holdoff();
    test_block_overflow();
    test_random_blocks();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_windows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ecw_pkg.sv
rtl/ecw_seq.sv
rtl/ecw_datapath.sv
rtl/energy_containment_window.sv
test/energy_containment_window_tb.sv
